@@ rtl/lprd_pkg.sv @@
`default_nettype none
package lprd_pkg;

  localparam int unsigned QUEUE_DEPTH_DEFAULT = 4;

  localparam logic [31:0] MAX_LEN_RESET  = 32'd4096;
  localparam logic [15:0] MAX_ARGS_RESET = 16'd1024;

  localparam int unsigned CFG_INDEX_W = 8;
  localparam logic [CFG_INDEX_W-1:0] CFG_MAX_MESSAGE_LENGTH = 8'd0;
  localparam logic [CFG_INDEX_W-1:0] CFG_MAX_ARGUMENT_COUNT = 8'd1;

  localparam logic [1:0] KIND_ARG_BYTE = 2'd0;
  localparam logic [1:0] KIND_ACCEPTED = 2'd1;
  localparam logic [1:0] KIND_TOO_LONG = 2'd2;
  localparam logic [1:0] KIND_BAD      = 2'd3;

  localparam logic [2:0] CLASS_GET     = 3'd0;
  localparam logic [2:0] CLASS_SET     = 3'd1;
  localparam logic [2:0] CLASS_DEL     = 3'd2;
  localparam logic [2:0] CLASS_KEYS    = 3'd3;
  localparam logic [2:0] CLASS_UNKNOWN = 3'd4;

  typedef struct packed {
    logic [31:0] max_message_length;
    logic [15:0] max_argument_count;
  } cfg_t;

  // one queue entry: an optional argument byte and an optional verdict after it
  typedef struct packed {
    logic        byte_valid;
    logic [7:0]  arg_byte;
    logic [15:0] arg_index;
    logic        arg_last;
    logic        verdict_valid;
    logic [1:0]  verdict_kind;
    logic [2:0]  command_class;
    logic [15:0] arg_total;
  } rec_t;

endpackage
`default_nettype wire

@@ rtl/lprd_front.sv @@
`default_nettype none
module lprd_front (
  input  wire                 clk,
  input  wire                 rst_n,
  input  lprd_pkg::cfg_t      cfg,
  input  wire                 in_valid,
  output logic                in_ready,
  input  wire  [7:0]          in_byte,
  input  wire                 in_restart,
  input  wire                 q_ready,
  output logic                push,
  output lprd_pkg::rec_t      rec
);

  typedef enum logic [4:0] {
    PH_LEN    = 5'b00001,
    PH_COUNT  = 5'b00010,
    PH_ALEN   = 5'b00100,
    PH_ABYTES = 5'b01000,
    PH_END    = 5'b10000
  } phase_t;

  localparam logic [31:0] TXT_GET  = 32'h0074_6567;
  localparam logic [31:0] TXT_SET  = 32'h0074_6573;
  localparam logic [31:0] TXT_DEL  = 32'h006c_6564;
  localparam logic [31:0] TXT_KEYS = 32'h7379_656b;

  phase_t      phase_r, phase_nxt;
  logic [1:0]  wbc_r, wbc_nxt;
  logic [31:0] acc_r, acc_nxt;
  logic [31:0] body_rem_r, body_rem_nxt;
  logic [15:0] args_exp_r, args_exp_nxt;
  logic [15:0] cur_arg_r, cur_arg_nxt;
  logic [31:0] abl_r, abl_nxt;
  logic [2:0]  fal_r, fal_nxt;
  logic [31:0] fat_r, fat_nxt;
  logic        bad_r, bad_nxt;
  logic        closed_r, closed_nxt;

  logic accept;

  function automatic logic [2:0] classify(input logic [15:0] n, input logic [2:0] len,
                                          input logic [31:0] txt);
    logic [2:0] c;
    c = lprd_pkg::CLASS_UNKNOWN;
    if (n == 16'd2 && len == 3'd3 && txt == TXT_GET) c = lprd_pkg::CLASS_GET;
    else if (n == 16'd3 && len == 3'd3 && txt == TXT_SET) c = lprd_pkg::CLASS_SET;
    else if (n == 16'd2 && len == 3'd3 && txt == TXT_DEL) c = lprd_pkg::CLASS_DEL;
    else if (n == 16'd1 && len == 3'd4 && txt == TXT_KEYS) c = lprd_pkg::CLASS_KEYS;
    return c;
  endfunction

  assign in_ready = q_ready;
  assign accept   = in_valid && q_ready;
  assign push     = accept && (rec.byte_valid || rec.verdict_valid);

  always_comb begin
    logic [31:0] word;
    logic        word_done;
    logic [31:0] rem;
    logic [15:0] ca1;
    word         = acc_r | ({24'd0, in_byte} << {wbc_r, 3'b000});
    word_done    = (wbc_r == 2'd3);
    rem          = body_rem_r - 32'd1;
    ca1          = cur_arg_r + 16'd1;
    phase_nxt    = phase_r;
    wbc_nxt      = wbc_r;
    acc_nxt      = acc_r;
    body_rem_nxt = body_rem_r;
    args_exp_nxt = args_exp_r;
    cur_arg_nxt  = cur_arg_r;
    abl_nxt      = abl_r;
    fal_nxt      = fal_r;
    fat_nxt      = fat_r;
    bad_nxt      = bad_r;
    closed_nxt   = closed_r;
    rec          = '0;

    if (in_restart) begin
      phase_nxt    = PH_LEN;
      wbc_nxt      = '0;
      acc_nxt      = '0;
      body_rem_nxt = '0;
      args_exp_nxt = '0;
      cur_arg_nxt  = '0;
      abl_nxt      = '0;
      fal_nxt      = '0;
      fat_nxt      = '0;
      bad_nxt      = 1'b0;
      closed_nxt   = 1'b0;
    end else if (!closed_r) begin
      if (phase_r == PH_LEN) begin
        wbc_nxt = wbc_r + 2'd1;
        acc_nxt = word;
        if (word_done) begin
          acc_nxt = '0;
          if (word > cfg.max_message_length) begin
            rec.verdict_valid = 1'b1;
            rec.verdict_kind  = lprd_pkg::KIND_TOO_LONG;
            closed_nxt        = 1'b1;
          end else if (word == 32'd0) begin
            rec.verdict_valid = 1'b1;
            rec.verdict_kind  = lprd_pkg::KIND_BAD;
            closed_nxt        = 1'b1;
          end else begin
            body_rem_nxt = word;
            phase_nxt    = PH_COUNT;
            bad_nxt      = 1'b0;
            args_exp_nxt = '0;
            cur_arg_nxt  = '0;
            abl_nxt      = '0;
            fal_nxt      = '0;
            fat_nxt      = '0;
          end
        end
      end else begin
        body_rem_nxt = rem;
        if (!bad_r) begin
          unique case (phase_r)
            PH_COUNT: begin
              wbc_nxt = wbc_r + 2'd1;
              acc_nxt = word;
              if (word_done) begin
                acc_nxt = '0;
                if (word > {16'd0, cfg.max_argument_count}) begin
                  bad_nxt = 1'b1;
                end else begin
                  args_exp_nxt = word[15:0];
                  cur_arg_nxt  = '0;
                  phase_nxt    = (word == 32'd0) ? PH_END : PH_ALEN;
                end
              end
            end
            PH_ALEN: begin
              wbc_nxt = wbc_r + 2'd1;
              acc_nxt = word;
              if (word_done) begin
                acc_nxt = '0;
                if (word > rem) begin
                  bad_nxt = 1'b1;
                end else if (word == 32'd0) begin
                  cur_arg_nxt = ca1;
                  phase_nxt   = (ca1 == args_exp_r) ? PH_END : PH_ALEN;
                end else begin
                  abl_nxt   = word;
                  phase_nxt = PH_ABYTES;
                end
              end
            end
            PH_ABYTES: begin
              if (cur_arg_r == 16'd0) begin
                if (fal_r < 3'd4) fat_nxt = fat_r | ({24'd0, in_byte} << {fal_r[1:0], 3'b000});
                if (fal_r < 3'd5) fal_nxt = fal_r + 3'd1;
              end
              rec.byte_valid = 1'b1;
              rec.arg_byte   = in_byte;
              rec.arg_index  = cur_arg_r;
              rec.arg_last   = (abl_r == 32'd1);
              abl_nxt        = abl_r - 32'd1;
              if (abl_r == 32'd1) begin
                cur_arg_nxt = ca1;
                phase_nxt   = (ca1 == args_exp_r) ? PH_END : PH_ALEN;
              end
            end
            PH_END: begin
              bad_nxt = 1'b1;
            end
            default: begin
              bad_nxt = 1'b1;
            end
          endcase
        end
        if (rem == 32'd0) begin
          rec.verdict_valid = 1'b1;
          if (bad_nxt || phase_nxt != PH_END) begin
            rec.verdict_kind = lprd_pkg::KIND_BAD;
            closed_nxt       = 1'b1;
          end else begin
            rec.verdict_kind  = lprd_pkg::KIND_ACCEPTED;
            rec.command_class = classify(args_exp_nxt, fal_nxt, fat_nxt);
            rec.arg_total     = args_exp_nxt;
          end
          phase_nxt = PH_LEN;
          wbc_nxt   = '0;
          acc_nxt   = '0;
          bad_nxt   = 1'b0;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r    <= PH_LEN;
      wbc_r      <= '0;
      acc_r      <= '0;
      body_rem_r <= '0;
      args_exp_r <= '0;
      cur_arg_r  <= '0;
      abl_r      <= '0;
      fal_r      <= '0;
      fat_r      <= '0;
      bad_r      <= 1'b0;
      closed_r   <= 1'b0;
    end else if (accept) begin
      phase_r    <= phase_nxt;
      wbc_r      <= wbc_nxt;
      acc_r      <= acc_nxt;
      body_rem_r <= body_rem_nxt;
      args_exp_r <= args_exp_nxt;
      cur_arg_r  <= cur_arg_nxt;
      abl_r      <= abl_nxt;
      fal_r      <= fal_nxt;
      fat_r      <= fat_nxt;
      bad_r      <= bad_nxt;
      closed_r   <= closed_nxt;
    end
  end

endmodule
`default_nettype wire

@@ rtl/lprd_queue.sv @@
`default_nettype none
module lprd_queue #(
  parameter int unsigned DEPTH = lprd_pkg::QUEUE_DEPTH_DEFAULT
) (
  input  wire             clk,
  input  wire             rst_n,
  input  wire             push,
  input  lprd_pkg::rec_t  push_data,
  output logic            ready,
  input  wire             pop,
  output logic            valid,
  output lprd_pkg::rec_t  pop_data
);

  localparam int unsigned PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CNT_W = $clog2(DEPTH + 1);
  localparam logic [PTR_W-1:0] LAST_PTR = PTR_W'(DEPTH - 1);
  localparam logic [CNT_W-1:0] FULL_CNT = CNT_W'(DEPTH);

  lprd_pkg::rec_t mem [DEPTH];

  logic [PTR_W-1:0] wr_ptr_r, rd_ptr_r;
  logic [CNT_W-1:0] count_r;

  assign ready    = (count_r != FULL_CNT);
  assign valid    = (count_r != '0);
  assign pop_data = mem[rd_ptr_r];

  always_ff @(posedge clk) begin
    if (push) mem[wr_ptr_r] <= push_data;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      if (push) wr_ptr_r <= (wr_ptr_r == LAST_PTR) ? '0 : wr_ptr_r + PTR_W'(1);
      if (pop)  rd_ptr_r <= (rd_ptr_r == LAST_PTR) ? '0 : rd_ptr_r + PTR_W'(1);
      if (push && !pop) count_r <= count_r + CNT_W'(1);
      else if (pop && !push) count_r <= count_r - CNT_W'(1);
    end
  end

endmodule
`default_nettype wire

@@ rtl/lprd_back.sv @@
`default_nettype none
module lprd_back (
  input  wire             clk,
  input  wire             rst_n,
  input  wire             q_valid,
  input  lprd_pkg::rec_t  q_data,
  output logic            pop,
  output logic            out_valid,
  input  wire             out_ready,
  output logic [1:0]      event_kind,
  output logic [7:0]      arg_byte,
  output logic [15:0]     arg_index,
  output logic            arg_last,
  output logic [2:0]      command_class,
  output logic [15:0]     arg_total,
  output logic            frame_last
);

  lprd_pkg::rec_t cur_r;
  logic           cur_valid_r;
  logic           byte_done_r;

  logic show_byte;
  logic fire;
  logic finish;

  assign show_byte = cur_r.byte_valid && !byte_done_r;
  assign fire      = cur_valid_r && out_ready;
  assign finish    = fire && !(show_byte && cur_r.verdict_valid);
  assign pop       = q_valid && (!cur_valid_r || finish);

  assign out_valid     = cur_valid_r;
  assign event_kind    = show_byte ? lprd_pkg::KIND_ARG_BYTE : cur_r.verdict_kind;
  assign arg_byte      = show_byte ? cur_r.arg_byte : 8'd0;
  assign arg_index     = show_byte ? cur_r.arg_index : 16'd0;
  assign arg_last      = show_byte ? cur_r.arg_last : 1'b0;
  assign command_class = show_byte ? 3'd0 : cur_r.command_class;
  assign arg_total     = show_byte ? 16'd0 : cur_r.arg_total;
  assign frame_last    = show_byte ? !cur_r.verdict_valid : 1'b1;

  always_ff @(posedge clk) begin
    if (pop) cur_r <= q_data;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cur_valid_r <= 1'b0;
      byte_done_r <= 1'b0;
    end else begin
      if (pop) begin
        cur_valid_r <= 1'b1;
        byte_done_r <= 1'b0;
      end else if (finish) begin
        cur_valid_r <= 1'b0;
      end else if (fire) begin
        byte_done_r <= 1'b1;
      end
    end
  end

endmodule
`default_nettype wire

@@ rtl/length_prefixed_request_deframer_unit.sv @@
// Length-prefixed request deframer: takes one connection byte per request on the in_
// stream (in_tdata = byte, in_tuser[0] = restart) and passes argument bytes through with
// their index and last mark, then a verdict (accepted with command class and argument
// count, length too large, or bad request) when each message body ends or its length
// word is refused. After an error bytes are dropped until a restart request. One input
// byte is taken and parsed every cycle while in_tready is high. A byte that both ends an
// argument and ends the body yields two results, which the output side sends one after
// the other; a small queue between parser and output lets the input keep running while
// results wait, and in_tready drops only while that queue is full.
// Configuration: index 0 max message length, index 1 max argument count.
`default_nettype none
module length_prefixed_request_deframer_unit #(
  parameter int unsigned QUEUE_DEPTH = lprd_pkg::QUEUE_DEPTH_DEFAULT
) (
  input  wire                              clk,
  input  wire                              rst_n,
  input  wire                              in_tvalid,
  output logic                             in_tready,
  input  wire  [7:0]                       in_tdata,   // in_byte
  input  wire  [0:0]                       in_tuser,   // restart
  output logic                             out_tvalid,
  input  wire                              out_tready,
  // event_kind, arg_byte, arg_index, arg_last, command_class, arg_total, zero pad
  output logic [47:0]                      out_tdata,
  output logic                             out_tlast,
  input  wire                              cfg_valid,
  output logic                             cfg_ready,
  input  wire  [lprd_pkg::CFG_INDEX_W-1:0] cfg_index,
  input  wire  [31:0]                      cfg_data
);

  lprd_pkg::cfg_t cfg_r;
  lprd_pkg::rec_t front_rec;
  lprd_pkg::rec_t q_data;

  logic        push, q_ready, q_valid, pop;
  logic [1:0]  event_kind;
  logic [7:0]  arg_byte;
  logic [15:0] arg_index;
  logic        arg_last;
  logic [2:0]  command_class;
  logic [15:0] arg_total;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.max_message_length <= lprd_pkg::MAX_LEN_RESET;
      cfg_r.max_argument_count <= lprd_pkg::MAX_ARGS_RESET;
    end else if (cfg_valid) begin
      unique case (cfg_index)
        lprd_pkg::CFG_MAX_MESSAGE_LENGTH: cfg_r.max_message_length <= cfg_data;
        lprd_pkg::CFG_MAX_ARGUMENT_COUNT: cfg_r.max_argument_count <= cfg_data[15:0];
        default: begin
        end
      endcase
    end
  end

  lprd_front u_front (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg        (cfg_r),
    .in_valid   (in_tvalid),
    .in_ready   (in_tready),
    .in_byte    (in_tdata),
    .in_restart (in_tuser[0]),
    .q_ready    (q_ready),
    .push       (push),
    .rec        (front_rec)
  );

  lprd_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (push),
    .push_data (front_rec),
    .ready     (q_ready),
    .pop       (pop),
    .valid     (q_valid),
    .pop_data  (q_data)
  );

  lprd_back u_back (
    .clk           (clk),
    .rst_n         (rst_n),
    .q_valid       (q_valid),
    .q_data        (q_data),
    .pop           (pop),
    .out_valid     (out_tvalid),
    .out_ready     (out_tready),
    .event_kind    (event_kind),
    .arg_byte      (arg_byte),
    .arg_index     (arg_index),
    .arg_last      (arg_last),
    .command_class (command_class),
    .arg_total     (arg_total),
    .frame_last    (out_tlast)
  );

  assign out_tdata = {2'b00, arg_total, command_class, arg_last, arg_index, arg_byte,
                      event_kind};

`ifndef ASSERT_OFF
  a_push_has_room: assert property (@(posedge clk) disable iff (!rst_n)
    push |-> q_ready) else $error("push into full queue");

  a_verdict_ends_frame: assert property (@(posedge clk) disable iff (!rst_n)
    (out_tvalid && event_kind != lprd_pkg::KIND_ARG_BYTE) |-> out_tlast)
    else $error("verdict without frame end");

  a_open_frame_is_byte: assert property (@(posedge clk) disable iff (!rst_n)
    (out_tvalid && !out_tlast) |-> (event_kind == lprd_pkg::KIND_ARG_BYTE))
    else $error("non-byte result before frame end");

  a_class_only_on_accept: assert property (@(posedge clk) disable iff (!rst_n)
    (out_tvalid && event_kind != lprd_pkg::KIND_ACCEPTED)
      |-> (command_class == 3'd0 && arg_total == 16'd0))
    else $error("class or total outside accept");
`endif

endmodule
`default_nettype wire
